### rtl/uab_pkg.sv
// ---------------------------------------------------------------------------
// uab_pkg
// Types and constants shared by the up-aligned bearing block.
// ---------------------------------------------------------------------------
package uab_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int MAX_STEPS    = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

	localparam int DIFF_W  = COORD_WIDTH + 1;   // point difference
	localparam int FIX_W   = DIFF_W + 1;        // negated difference
	localparam int Q_W     = 16;                // quaternion component, Q1.14
	localparam int MAT_W   = 32;                // rotation matrix entry
	localparam int PROD_W  = MAT_W + DIFF_W;
	localparam int SUM_W   = PROD_W + 2;        // exact rotated component
	localparam int SHIFT_W = $clog2(SUM_W);
	localparam int SPLIT_BITS = 24;
	localparam int BIG_BIT    = 29;
	localparam int KEEP_BITS  = 30;             // CORDIC input below 2^30
	localparam int A_W     = 34;                // CORDIC vector
	localparam int Z_W     = 26;                // angle, 1/32768 degree
	localparam int ATAN_W  = 22;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int HEAD_W  = 16;

	localparam int HEADING_FULL = 46080;
	localparam int HALF_TURN    = 180 * 32768;
	localparam int ROUND_HALF   = 128;
	localparam int ROUND_SHIFT  = 8;

	// pipeline depth from the accepting edge to the result, as sampled
	localparam int PIPE_DEPTH = CORDIC_N + 8;

	typedef enum logic [IDX_W-1:0] {
		REG_UP_MODE  = 3'd0,
		REG_UP_NEG   = 3'd1,
		REG_CUSTOM_W = 3'd2,
		REG_CUSTOM_X = 3'd3,
		REG_CUSTOM_Y = 3'd4,
		REG_CUSTOM_Z = 3'd5,
		REG_NORTH    = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_CUSTOM = 2'd0,
		MODE_X_UP   = 2'd1,
		MODE_Y_UP   = 2'd2,
		MODE_Z_UP   = 2'd3
	} up_mode_t;

	// atan(2^-i) in 1/32768 degree
	localparam logic [ATAN_W-1:0] ATAN_TAB [MAX_STEPS] = '{
		22'd1474560, 22'd870484, 22'd459940, 22'd233473, 22'd117189, 22'd58652,
		22'd29333,   22'd14667,  22'd7334,   22'd3667,   22'd1833,   22'd917,
		22'd458,     22'd229,    22'd115,    22'd57,     22'd29,     22'd14,
		22'd7,       22'd4,      22'd2,      22'd1,      22'd0,      22'd0
	};

endpackage

### rtl/up_aligned_bearing.sv
// ---------------------------------------------------------------------------
// up_aligned_bearing
// Bearing of the segment between two 3-D points in an up-aligned frame.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken on each rising edge with start high and busy low;
//   busy stays low, so a point pair may be offered every cycle.
//   Each pair gives one result: done pulses for one cycle with heading and
//   fallback_used valid in that cycle. Results come out in order.
//   Each pair passes through the stages difference, rotate multiply,
//   rotate sum, magnitude select, shift search, scale, quadrant fold,
//   one stage per CORDIC step, output register.
//   Throughput is one pair per cycle.
//   The receiver cannot stall; done is a plain strobe.
//   Configuration is written through wr_en/wr_index/wr_data while no
//   transaction is in flight; it takes effect for pairs accepted afterwards.
//   Reset clears the pipeline valid bits and loads Z-up, no flip, identity
//   quaternion and a fallback heading of zero.
// ---------------------------------------------------------------------------
module up_aligned_bearing (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  logic [uab_pkg::IDX_W-1:0]                 wr_index,
	input  logic [uab_pkg::CFG_W-1:0]                 wr_data,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [uab_pkg::COORD_WIDTH-1:0]    first_x,
	input  logic signed [uab_pkg::COORD_WIDTH-1:0]    first_y,
	input  logic signed [uab_pkg::COORD_WIDTH-1:0]    first_z,
	input  logic signed [uab_pkg::COORD_WIDTH-1:0]    second_x,
	input  logic signed [uab_pkg::COORD_WIDTH-1:0]    second_y,
	input  logic signed [uab_pkg::COORD_WIDTH-1:0]    second_z,
	output logic                                      done,
	output logic [uab_pkg::HEAD_W-1:0]                heading,
	output logic                                      fallback_used
);
	import uab_pkg::*;

	// configuration
	up_mode_t              up_mode_q;
	logic                  up_neg_q;
	logic signed [Q_W-1:0] cw_q, cx_q, cy_q, cz_q;
	logic [HEAD_W-1:0]     north_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_mode_q <= MODE_Z_UP;
			up_neg_q  <= 1'b0;
			cw_q      <= 16'sd16384;
			cx_q      <= '0;
			cy_q      <= '0;
			cz_q      <= '0;
			north_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_UP_MODE:  up_mode_q <= up_mode_t'(wr_data[1:0]);
				REG_UP_NEG:   up_neg_q  <= wr_data[0];
				REG_CUSTOM_W: cw_q      <= wr_data;
				REG_CUSTOM_X: cx_q      <= wr_data;
				REG_CUSTOM_Y: cy_q      <= wr_data;
				REG_CUSTOM_Z: cz_q      <= wr_data;
				REG_NORTH:    north_q   <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// rotation matrix rows 0 and 1 of q*v*conj(q), refreshed from config
	logic signed [MAT_W-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
	logic signed [MAT_W-1:0] mat_q [6];

	assign ww = cw_q * cw_q;
	assign xx = cx_q * cx_q;
	assign yy = cy_q * cy_q;
	assign zz = cz_q * cz_q;
	assign xy = cx_q * cy_q;
	assign wz = cw_q * cz_q;
	assign xz = cx_q * cz_q;
	assign wy = cw_q * cy_q;
	assign yz = cy_q * cz_q;
	assign wx = cw_q * cx_q;

	always_ff @(posedge clk) begin
		mat_q[0] <= ww + xx - yy - zz;
		mat_q[1] <= (xy - wz) <<< 1;
		mat_q[2] <= (xz + wy) <<< 1;
		mat_q[3] <= (xy + wz) <<< 1;
		mat_q[4] <= ww - xx + yy - zz;
		mat_q[5] <= (yz - wx) <<< 1;
	end

	// stage 1: difference
	logic                     vld_s1, dzero_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		dx_s1    <= {second_x[COORD_WIDTH-1], second_x} - {first_x[COORD_WIDTH-1], first_x};
		dy_s1    <= {second_y[COORD_WIDTH-1], second_y} - {first_y[COORD_WIDTH-1], first_y};
		dz_s1    <= {second_z[COORD_WIDTH-1], second_z} - {first_z[COORD_WIDTH-1], first_z};
		dzero_s1 <= (first_x == second_x) && (first_y == second_y) && (first_z == second_z);
	end

	// stage 2: matrix products and fixed remap
	logic                     vld_s2, dzero_s2, custom_s2;
	logic signed [PROD_W-1:0] prod_s2 [6];
	logic signed [FIX_W-1:0]  pxf_s2, pyf_s2;
	logic signed [FIX_W-1:0]  ex, ey, ez, pxf, pyf;

	assign ex = FIX_W'(dx_s1);
	assign ey = FIX_W'(dy_s1);
	assign ez = FIX_W'(dz_s1);

	always_comb begin
		unique case (up_mode_q)
			MODE_X_UP: begin
				pxf = up_neg_q ? ez : -ez;
				pyf = ey;
			end
			MODE_Y_UP: begin
				pxf = ex;
				pyf = up_neg_q ? ez : -ez;
			end
			default: begin
				pxf = ex;
				pyf = up_neg_q ? -ey : ey;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		prod_s2[0] <= mat_q[0] * dx_s1;
		prod_s2[1] <= mat_q[1] * dy_s1;
		prod_s2[2] <= mat_q[2] * dz_s1;
		prod_s2[3] <= mat_q[3] * dx_s1;
		prod_s2[4] <= mat_q[4] * dy_s1;
		prod_s2[5] <= mat_q[5] * dz_s1;
		pxf_s2     <= pxf;
		pyf_s2     <= pyf;
		custom_s2  <= (up_mode_q == MODE_CUSTOM);
		dzero_s2   <= dzero_s1;
	end

	// stage 3: exact planar part and zero test
	logic                    vld_s3, fb_s3;
	logic signed [SUM_W-1:0] px_s3, py_s3, px_full, py_full;

	always_comb begin
		if (custom_s2) begin
			px_full = SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]) + SUM_W'(prod_s2[2]);
			py_full = SUM_W'(prod_s2[3]) + SUM_W'(prod_s2[4]) + SUM_W'(prod_s2[5]);
		end else begin
			px_full = SUM_W'(pxf_s2);
			py_full = SUM_W'(pyf_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		px_s3 <= px_full;
		py_s3 <= py_full;
		fb_s3 <= dzero_s2 || (px_full == '0 && py_full == '0);
	end

	// stage 4: coarse select and magnitudes
	logic                    vld_s4, fb_s4, sp_s4, sq_s4;
	logic [SUM_W-1:0]        mp_s4, mq_s4;
	logic signed [SUM_W-1:0] hp, hq, vp, vq;
	logic                    big;

	assign hp  = px_s3 >>> SPLIT_BITS;
	assign hq  = py_s3 >>> SPLIT_BITS;
	assign big = hp >= (SUM_W'(1) <<< BIG_BIT) || hp <= -(SUM_W'(1) <<< BIG_BIT)
	          || hq >= (SUM_W'(1) <<< BIG_BIT) || hq <= -(SUM_W'(1) <<< BIG_BIT);
	assign vp  = big ? hp : px_s3;
	assign vq  = big ? hq : py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		sp_s4 <= vp[SUM_W-1];
		sq_s4 <= vq[SUM_W-1];
		mp_s4 <= vp[SUM_W-1] ? -vp : vp;
		mq_s4 <= vq[SUM_W-1] ? -vq : vq;
		fb_s4 <= fb_s3;
	end

	// stage 5: shift search on the larger magnitude
	logic               vld_s5, fb_s5, sp_s5, sq_s5;
	logic [SUM_W-1:0]   mp_s5, mq_s5, m_or;
	logic [SHIFT_W-1:0] sh_s5, msb, sh;

	assign m_or = mp_s4 | mq_s4;

	always_comb begin
		msb = '0;
		for (int i = 0; i < SUM_W; i++) begin
			if (m_or[i]) msb = SHIFT_W'(i);
		end
		sh = (msb >= SHIFT_W'(KEEP_BITS)) ? msb - SHIFT_W'(KEEP_BITS - 1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		mp_s5 <= mp_s4;
		mq_s5 <= mq_s4;
		sp_s5 <= sp_s4;
		sq_s5 <= sq_s4;
		sh_s5 <= sh;
		fb_s5 <= fb_s4;
	end

	// stage 6: scale to CORDIC range, a from planar y, b from planar x
	logic                  vld_s6, fb_s6;
	logic signed [A_W-1:0] a_s6, b_s6, am, bm;
	logic [SUM_W-1:0]      ap, bp;

	assign ap = mq_s5 >> sh_s5;
	assign bp = mp_s5 >> sh_s5;
	assign am = A_W'(signed'({1'b0, ap[KEEP_BITS-1:0]}));
	assign bm = A_W'(signed'({1'b0, bp[KEEP_BITS-1:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		a_s6  <= sq_s5 ? -am : am;
		b_s6  <= sp_s5 ? -bm : bm;
		fb_s6 <= fb_s5;
	end

	// CORDIC: entry 0 is the quadrant fold, entry k is after step k-1
	logic signed [A_W-1:0] cor_a_s [CORDIC_N+1];
	logic signed [A_W-1:0] cor_b_s [CORDIC_N+1];
	logic signed [Z_W-1:0] cor_z_s [CORDIC_N+1];
	logic                  cor_v_s [CORDIC_N+1];
	logic                  cor_fb_s[CORDIC_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cor_v_s[0] <= 1'b0;
		else         cor_v_s[0] <= vld_s6;
	end

	always_ff @(posedge clk) begin
		cor_a_s[0]  <= a_s6[A_W-1] ? -a_s6 : a_s6;
		cor_b_s[0]  <= a_s6[A_W-1] ? -b_s6 : b_s6;
		cor_z_s[0]  <= a_s6[A_W-1] ? Z_W'(HALF_TURN) : '0;
		cor_fb_s[0] <= fb_s6;
	end

	for (genvar k = 1; k <= CORDIC_N; k++) begin : g_step
		logic signed [A_W-1:0] sa, sb;
		logic signed [Z_W-1:0] ang;
		logic                  pos;

		assign sa  = cor_a_s[k-1] >>> (k - 1);
		assign sb  = cor_b_s[k-1] >>> (k - 1);
		assign ang = Z_W'(signed'({1'b0, ATAN_TAB[k-1]}));
		assign pos = !cor_b_s[k-1][A_W-1] && (cor_b_s[k-1] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cor_v_s[k] <= 1'b0;
			else         cor_v_s[k] <= cor_v_s[k-1];
		end

		always_ff @(posedge clk) begin
			cor_a_s[k]  <= pos ? cor_a_s[k-1] + sb : cor_a_s[k-1] - sb;
			cor_b_s[k]  <= pos ? cor_b_s[k-1] - sa : cor_b_s[k-1] + sa;
			cor_z_s[k]  <= pos ? cor_z_s[k-1] + ang : cor_z_s[k-1] - ang;
			cor_fb_s[k] <= cor_fb_s[k-1];
		end
	end

	// output: round to 1/128 degree and wrap
	logic signed [Z_W-1:0] z_rnd, h_raw, h_wrap;
	logic                  done_q, fb_q;
	logic [HEAD_W-1:0]     heading_q;

	assign z_rnd  = cor_z_s[CORDIC_N] + Z_W'(ROUND_HALF);
	assign h_raw  = z_rnd >>> ROUND_SHIFT;
	assign h_wrap = h_raw[Z_W-1] ? h_raw + Z_W'(HEADING_FULL) : h_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= cor_v_s[CORDIC_N];
	end

	always_ff @(posedge clk) begin
		fb_q      <= cor_fb_s[CORDIC_N];
		heading_q <= cor_fb_s[CORDIC_N] ? north_q : h_wrap[HEAD_W-1:0];
	end

	assign done          = done_q;
	assign heading       = heading_q;
	assign fallback_used = fb_q;

	// every accepted pair yields exactly one result after the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_DEPTH done)
		else $error("result missing after accepted pair");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_DEPTH))
		else $error("result without an accepted pair");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !fallback_used |-> heading < HEAD_W'(HEADING_FULL))
		else $error("computed heading out of range");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		done && fallback_used |-> heading == north_q)
		else $error("fallback heading mismatch");

endmodule
